@@ rtl/rrts_pkg.sv @@
// Shared types and codes for the round-robin task slot scheduler.
package rrts_pkg;

    // Item codes
    localparam logic ACT_CREATE   = 1'b0;
    localparam logic ACT_SCHEDULE = 1'b1;

    // Result status codes
    localparam logic [1:0] STS_SWITCHED = 2'd0;
    localparam logic [1:0] STS_IGNORED  = 2'd1;
    localparam logic [1:0] STS_KEPT     = 2'd2;
    localparam logic [1:0] STS_FULL     = 2'd3;

    // Slot state codes
    localparam logic [1:0] SLOT_READY   = 2'd0;
    localparam logic [1:0] SLOT_RUNNING = 2'd1;
    localparam logic [1:0] SLOT_TERM    = 2'd2;

    // Exit marker pair in the saved registers
    localparam logic [31:0] EXIT_EAX = 32'hDEADDEAD;
    localparam logic [31:0] EXIT_EBP = 32'h0000_0000;

    typedef struct packed {
        logic        action;
        logic [31:0] saved_eax;
        logic [31:0] saved_ebp;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_index;
        logic [31:0] task_number;
        logic        ended_flag;
        logic        bootstrap_flag;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic create;
        logic full;
        logic ignore;
        logic boot;
        logic sched;
        logic retire;
        logic advance;
        logic hit;
        logic miss;
        logic emit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic skip;
        logic boot;
        logic hit;
        logic at_start;
    } t_stat;

endpackage

@@ rtl/round_robin_task_slot_scheduler.sv @@
// Top level of the round-robin task slot scheduler.
//
// Command channel: an item (create or schedule) transfers at a rising edge
// with start high and busy low. Each item gives exactly one result on
// o_result, marked by o_strobe for one cycle; the receiver cannot hold it.
// Create, table-full and ignored schedule items: the result is registered
// and shows in the cycle after the transfer; busy stays low, so one item
// per cycle is taken. A schedule item that runs: a retire step (skipped
// for the bootstrap case), then the cyclic scan over the slot table at one
// slot per cycle, then a finish step for the task number RAM read.
// busy is high from the cycle after the transfer until the result shows.
// User writes enable via i_cfg_we / i_cfg_wdata only when idle; unchecked.
// Synchronous reset clears the slot table, the fill count, the current slot,
// sets the next task id to one and the enable to zero; no clearing pass.
module round_robin_task_slot_scheduler #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rrts_pkg::t_item   i_item,
    output rrts_pkg::t_result o_result,
    output logic              o_strobe,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);
    import rrts_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer
    rrts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_item.action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    // Datapath
    rrts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (o_result),
        .o_strobe    (o_strobe)
    );

    // Every transfer either has its result out next cycle or keeps busy high
    a_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("transferred item neither finished nor in progress");

endmodule

@@ rtl/rrts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rrts_ctrl.sv @@
// Sequencer for the scheduler: accept, retire, cyclic scan, finish.
module rrts_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_action,
    input  rrts_pkg::t_stat i_stat,
    output rrts_pkg::t_cmd  o_cmd,
    output logic           busy
);
    import rrts_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RETIRE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Command decode and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_CREATE) begin
                        if (i_stat.full) begin
                            o_cmd.full = 1'b1;
                        end else begin
                            o_cmd.create = 1'b1;
                        end
                    end else if (i_stat.skip) begin
                        o_cmd.ignore = 1'b1;
                    end else if (i_stat.boot) begin
                        o_cmd.boot = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        o_cmd.sched = 1'b1;
                        n_state     = S_RETIRE;
                    end
                end
            end
            S_RETIRE: begin
                o_cmd.retire = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_FINISH;
                end else if (i_stat.at_start) begin
                    o_cmd.miss = 1'b1;
                    n_state    = S_FINISH;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign busy = r_busy;

endmodule

@@ rtl/rrts_dp.sv @@
// Datapath: slot state table, task number RAM, counters and result register.
module rrts_dp #(
    parameter int SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  rrts_pkg::t_item   i_item,
    input  rrts_pkg::t_cmd    i_cmd,
    output rrts_pkg::t_stat   o_stat,
    output rrts_pkg::t_result o_result,
    output logic              o_strobe
);
    import rrts_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int XW = (SW > 4) ? SW : 4;

    function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] x);
        return (x == SW'(SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    logic          r_enable;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_next;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_ptr;
    logic [SW-1:0] r_start;
    logic          r_exit;
    logic          r_ended;
    logic          r_boot;
    logic          r_miss;
    logic [1:0]    r_st [SLOTS];
    t_result       r_out;
    logic          r_out_vld;

    logic          w_add;
    logic          w_used;
    logic [1:0]    w_st;
    logic          w_running;
    logic          w_st_we;
    logic [SW-1:0] w_st_idx;
    logic [1:0]    w_st_val;
    logic [31:0]   w_rdata;
    logic [XW-1:0] w_ptr_x;
    logic [XW-1:0] w_cnt_x;

    // Table lookups at the scan pointer
    assign w_add     = i_cmd.create | i_cmd.boot;
    assign w_used    = (CW'(r_ptr) < r_cnt);
    assign w_st      = r_st[r_ptr];
    assign w_running = w_used && (w_st == SLOT_RUNNING);
    assign w_ptr_x   = XW'(r_ptr);
    assign w_cnt_x   = XW'(r_cnt[SW-1:0]);

    // Status to the controller; slots fill from 0 upward and are never freed
    always_comb begin
        o_stat.full     = (r_cnt == CW'(SLOTS));
        o_stat.skip     = !r_enable || (r_cnt == '0);
        o_stat.boot     = (r_cnt == CW'(1));
        o_stat.hit      = w_used && (w_st == SLOT_READY);
        o_stat.at_start = (r_ptr == r_start);
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Slot state write port
    always_comb begin
        w_st_we  = 1'b0;
        w_st_idx = r_ptr;
        w_st_val = SLOT_RUNNING;
        if (w_add) begin
            w_st_we  = 1'b1;
            w_st_idx = r_cnt[SW-1:0];
            w_st_val = SLOT_READY;
        end else if (i_cmd.retire) begin
            w_st_we  = w_running;
            w_st_val = r_exit ? SLOT_TERM : SLOT_READY;
        end else if (i_cmd.hit) begin
            w_st_we  = 1'b1;
        end else if (i_cmd.miss) begin
            w_st_we  = w_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_st[i] <= SLOT_READY;
            end
        end else if (w_st_we) begin
            r_st[w_st_idx] <= w_st_val;
        end
    end

    // Task numbers
    rrts_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS),
        .AW    (SW)
    ) u_num_ram (
        .i_clk   (i_clk),
        .i_we    (w_add),
        .i_waddr (r_cnt[SW-1:0]),
        .i_wdata (r_next),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // Fill count, id counter and current slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_next <= 32'd1;
            r_cur  <= '0;
        end else begin
            if (w_add) begin
                r_cnt  <= r_cnt + 1'b1;
                r_next <= r_next + 32'd1;
            end
            if (i_cmd.boot) begin
                r_cur <= SW'(1);
            end else if (i_cmd.hit || i_cmd.miss) begin
                r_cur <= r_ptr;
            end
        end
    end

    // Scan pointer and per-item flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.boot) begin
            r_start <= SW'(1);
            r_ptr   <= f_inc(SW'(1));
            r_ended <= 1'b0;
            r_boot  <= 1'b1;
        end else if (i_cmd.sched) begin
            r_start <= r_cur;
            r_ptr   <= r_cur;
            r_ended <= 1'b0;
            r_boot  <= 1'b0;
            r_exit  <= (i_item.saved_eax == EXIT_EAX) && (i_item.saved_ebp == EXIT_EBP);
        end else if (i_cmd.retire) begin
            r_ended <= w_running && r_exit;
            r_ptr   <= f_inc(r_ptr);
        end else if (i_cmd.advance) begin
            r_ptr   <= f_inc(r_ptr);
        end
        if (i_cmd.hit) begin
            r_miss <= 1'b0;
        end else if (i_cmd.miss) begin
            r_miss <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.create) begin
            r_out <= '{status: STS_SWITCHED, slot_index: w_cnt_x[3:0],
                       task_number: r_next, ended_flag: 1'b0, bootstrap_flag: 1'b0};
        end else if (i_cmd.full) begin
            r_out <= '{status: STS_FULL, slot_index: 4'd0, task_number: 32'd0,
                       ended_flag: 1'b0, bootstrap_flag: 1'b0};
        end else if (i_cmd.ignore) begin
            r_out <= '{status: STS_IGNORED, slot_index: 4'd0, task_number: 32'd0,
                       ended_flag: 1'b0, bootstrap_flag: 1'b0};
        end else if (i_cmd.emit) begin
            r_out <= '{status: (r_miss ? STS_KEPT : STS_SWITCHED),
                       slot_index: w_ptr_x[3:0],
                       task_number: (w_used ? w_rdata : 32'd0),
                       ended_flag: r_ended, bootstrap_flag: r_boot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.create | i_cmd.full | i_cmd.ignore | i_cmd.emit;
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_out_vld;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(SLOTS))
        else $error("slot fill count beyond table size");

    a_boot_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.bootstrap_flag) |-> (r_cnt >= CW'(2)))
        else $error("bootstrap reported without a second used slot");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status == STS_FULL)) |-> (r_cnt == CW'(SLOTS)))
        else $error("table full reported with free slots");

endmodule
